### hw/rtl/constant_weight_word_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// constant weight word encoder assertion macros
// shared concurrent assertion forms, sampled on clk_i, off while in reset
// ----------------------------------------------------------------------------
`ifndef CONSTANT_WEIGHT_WORD_ENCODER_TOP_DEFINES_SVH
`define CONSTANT_WEIGHT_WORD_ENCODER_TOP_DEFINES_SVH

// same-cycle implication
`define CWE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cwe_pkg.sv
// ----------------------------------------------------------------------------
// cwe_pkg
// types, constants and the weight fraction table of the constant weight
// word encoder
// ----------------------------------------------------------------------------
`default_nettype none

package cwe_pkg;

  localparam int unsigned MaxLength = 4096;
  localparam int unsigned MaxWeight = 63;
  localparam int unsigned PosSpan   = 4096;
  localparam int unsigned LenCap    = (MaxLength < PosSpan) ? MaxLength : PosSpan;

  localparam int unsigned LenW     = 13;
  localparam int unsigned WtW      = 6;
  localparam int unsigned PosW     = 12;
  localparam int unsigned BaseW    = 13;
  localparam int unsigned BitsW    = 4;
  localparam int unsigned FracW    = 16;
  localparam int unsigned NumW     = 14;
  localparam int unsigned ProdW    = 30;
  localparam int unsigned RoundSh  = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [LenW-1:0]  LenCapV         = LenW'(LenCap);
  localparam logic [WtW-1:0]   MaxWeightV      = WtW'(MaxWeight);
  localparam logic [LenW-1:0]  CodeLengthReset = LenW'(2048);
  localparam logic [WtW-1:0]   WordWeightReset = WtW'(32);
  localparam logic [BaseW-1:0] BaseMax         = '1;
  localparam logic [ProdW:0]   RoundAdd        = (ProdW+1)'((1 << RoundSh) - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgCodeLength = 1'b0,
    CfgWordWeight = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhaseFlag  = 2'd0,
    PhaseValue = 2'd1,
    PhaseExtra = 2'd2
  } phase_e;

  // round(65536 * (1 - 2^(-1/t))) for t = 0..63
  localparam logic [FracW-1:0] WeightFrac [64] = '{
    16'd0,     16'd32768, 16'd19195, 16'd13520, 16'd10427, 16'd8484,  16'd7150,
    16'd6178,  16'd5439,  16'd4858,  16'd4389,  16'd4002,  16'd3678,  16'd3403,
    16'd3166,  16'd2960,  16'd2779,  16'd2618,  16'd2476,  16'd2348,  16'd2232,
    16'd2128,  16'd2033,  16'd1946,  16'd1866,  16'd1792,  16'd1724,  16'd1661,
    16'd1602,  16'd1548,  16'd1497,  16'd1449,  16'd1404,  16'd1362,  16'd1323,
    16'd1285,  16'd1250,  16'd1216,  16'd1185,  16'd1154,  16'd1126,  16'd1099,
    16'd1073,  16'd1048,  16'd1024,  16'd1002,  16'd980,   16'd959,   16'd940,
    16'd921,   16'd902,   16'd885,   16'd868,   16'd852,   16'd836,   16'd821,
    16'd806,   16'd792,   16'd779,   16'd765,   16'd753,   16'd740,   16'd729,
    16'd717
  };

  typedef struct packed {
    logic load_item;
    logic decode;
    logic mul;
    logic step;
    logic emit_take;
    logic emit_flush;
  } cwe_cmd_t;

  typedef struct packed {
    logic wt_zero;
    logic flush_need;
    logic phase_flag;
    logic decode_take;
    logic msg_bit;
    logic step_take;
    logic out_free;
  } cwe_status_t;

endpackage

`default_nettype wire

### hw/rtl/cwe_ctrl.sv
// ----------------------------------------------------------------------------
// cwe_ctrl
// sequencer of the encoder: takes one request at a time and steps the
// datapath through decode, step size, value take and flush
// ----------------------------------------------------------------------------
`default_nettype none

module cwe_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  cwe_pkg::cwe_status_t status_i,
  output cwe_pkg::cwe_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecode = 6'b000010,
    StMul    = 6'b000100,
    StStep   = 6'b001000,
    StTake   = 6'b010000,
    StFlush  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = StDecode;
        end
      end
      StDecode: begin
        if (status_i.wt_zero) begin
          state_d = StIdle;
        end else if (status_i.flush_need) begin
          // word fits at once after a start
          state_d = StFlush;
        end else if (status_i.phase_flag) begin
          state_d = StMul;
        end else begin
          cmd_o.decode = 1'b1;
          state_d      = status_i.decode_take ? StTake : StIdle;
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StStep;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        if (status_i.msg_bit) begin
          state_d = StFlush;
        end else if (status_i.step_take) begin
          state_d = StTake;
        end else begin
          state_d = StIdle;
        end
      end
      StTake: begin
        if (status_i.out_free) begin
          cmd_o.emit_take = 1'b1;
          state_d         = StFlush;
        end
      end
      StFlush: begin
        if (status_i.flush_need) begin
          cmd_o.emit_flush = status_i.out_free;
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cwe_dp.sv
// ----------------------------------------------------------------------------
// cwe_dp
// encoder datapath: configuration registers, word state, step size
// multiply, truncated binary value read and the output register
// ----------------------------------------------------------------------------
`default_nettype none

module cwe_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  input  wire  [cwe_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  wire  [cwe_pkg::CfgDataW-1:0]       cfg_data_i,
  input  wire                                msg_bit_i,
  input  wire                                start_word_i,
  input  cwe_pkg::cwe_cmd_t                  cmd_i,
  output cwe_pkg::cwe_status_t               status_o,
  input  wire                                out_ready_i,
  output logic                               out_valid_o,
  output logic [cwe_pkg::PosW-1:0]           position_o,
  output logic                               last_one_o
);

  localparam int unsigned LenW  = cwe_pkg::LenW;
  localparam int unsigned WtW   = cwe_pkg::WtW;
  localparam int unsigned PosW  = cwe_pkg::PosW;
  localparam int unsigned BaseW = cwe_pkg::BaseW;
  localparam int unsigned BitsW = cwe_pkg::BitsW;
  localparam int unsigned NumW  = cwe_pkg::NumW;
  localparam int unsigned ProdW = cwe_pkg::ProdW;

  // configuration
  logic [LenW-1:0] code_len_q;
  logic [WtW-1:0]  word_wt_q;

  // word state
  logic [LenW-1:0]       rem_len_q;
  logic [WtW-1:0]        rem_wt_q;
  logic [PosW-1:0]       gap_q;
  logic [BaseW-1:0]      base_q;
  cwe_pkg::phase_e       phase_q;
  logic [BitsW-1:0]      bits_left_q;
  logic [PosW-1:0]       partial_q;
  logic [PosW-1:0]       step_q;
  logic [PosW-1:0]       thr_q;
  logic                  msg_bit_q;
  logic [ProdW-1:0]      prod_q;
  logic [PosW-1:0]       c_q;
  logic                  out_valid_q;
  logic [PosW-1:0]       pos_q;
  logic                  last_q;

  // effective length and weight
  logic [LenW-1:0] eff_len;
  logic [WtW-1:0]  wt_cap;
  logic [WtW-1:0]  eff_wt;
  logic [LenW-1:0] lim_full;
  logic [PosW-1:0] lim;

  always_comb begin
    eff_len  = (code_len_q > cwe_pkg::LenCapV) ? cwe_pkg::LenCapV : code_len_q;
    wt_cap   = (word_wt_q > cwe_pkg::MaxWeightV) ? cwe_pkg::MaxWeightV : word_wt_q;
    eff_wt   = (LenW'(wt_cap) > eff_len) ? eff_len[WtW-1:0] : wt_cap;
    lim_full = eff_len - LenW'(1);
    lim      = (eff_len == '0) ? '0 : lim_full[PosW-1:0];
  end

  // status
  logic wt_zero;
  logic flush_need;
  assign wt_zero    = (rem_wt_q == '0);
  assign flush_need = !wt_zero && (rem_len_q <= LenW'(rem_wt_q));

  // value bit decode
  logic [PosW-1:0]  partial_shift;
  logic [BitsW-1:0] bits_dec;
  logic             step_small;
  logic [NumW-1:0]  ext_val;
  logic             dec_take;
  logic             dec_extra;
  logic [LenW-1:0]  dec_c_raw;
  logic             dec_c_huge;
  logic [PosW-1:0]  dec_c;

  always_comb begin
    partial_shift = {partial_q[PosW-2:0], msg_bit_q};
    bits_dec      = (bits_left_q != '0) ? bits_left_q - BitsW'(1) : '0;
    step_small    = (step_q < PosW'(2));
    ext_val       = {1'b0, partial_q, msg_bit_q} - NumW'(thr_q);
    dec_take      = 1'b0;
    dec_extra     = 1'b0;
    dec_c_raw     = '0;
    dec_c_huge    = 1'b0;
    case (phase_q)
      cwe_pkg::PhaseValue: begin
        if (bits_dec == '0) begin
          if (step_small) begin
            dec_take = 1'b1;
          end else if (partial_shift >= thr_q) begin
            dec_extra = 1'b1;
          end else begin
            dec_take  = 1'b1;
            dec_c_raw = LenW'(partial_shift);
          end
        end
      end
      cwe_pkg::PhaseExtra: begin
        dec_take = 1'b1;
        if (!step_small) begin
          dec_c_raw  = ext_val[LenW-1:0];
          dec_c_huge = ext_val[NumW-1];
        end
      end
      default: begin
        dec_take = 1'b0;
      end
    endcase
    // value never reaches the step size
    if ((step_q != '0) && (dec_c_huge || (dec_c_raw >= LenW'(step_q)))) begin
      dec_c = step_q - PosW'(1);
    end else begin
      dec_c = dec_c_raw[PosW-1:0];
    end
  end

  // step size from the registered product
  logic [NumW-1:0]  num;
  logic [ProdW:0]   d_sum;
  logic [NumW-1:0]  d_raw;
  logic [LenW-1:0]  span;
  logic             d_guard;
  logic [PosW-1:0]  step_d;
  logic [PosW-1:0]  dm1;
  logic [BitsW-1:0] u;
  logic [LenW-1:0]  thr_full;
  logic             step_take;

  always_comb begin
    num     = {rem_len_q, 1'b0} - NumW'(rem_wt_q) + NumW'(1);
    d_sum   = {1'b0, prod_q} + cwe_pkg::RoundAdd;
    d_raw   = d_sum[ProdW:cwe_pkg::RoundSh];
    span    = rem_len_q - LenW'(rem_wt_q);
    d_guard = wt_zero || (rem_len_q <= LenW'(rem_wt_q));
    if (d_guard || (d_raw == '0)) begin
      step_d = PosW'(1);
    end else if (d_raw > NumW'(span)) begin
      step_d = span[PosW-1:0];
    end else begin
      step_d = d_raw[PosW-1:0];
    end
    // ceil(log2 d) as the bit length of d - 1
    dm1 = step_d - PosW'(1);
    u   = '0;
    for (int i = 0; i < PosW; i++) begin
      if (dm1[i]) begin
        u = BitsW'(i + 1);
      end
    end
    thr_full  = (LenW'(1) << u) - LenW'(step_d);
    step_take = !msg_bit_q && (step_d < PosW'(2));
  end

  // placing one position
  logic [LenW-1:0]  put_gap;
  logic [NumW-1:0]  raw;
  logic [NumW-1:0]  raw1;
  logic [PosW-1:0]  put_pos;
  logic [BaseW-1:0] base_d;
  logic [WtW-1:0]   wt_dec;
  logic             emit;
  logic             out_free;

  always_comb begin
    put_gap = cmd_i.emit_take ? (LenW'(gap_q) + LenW'(c_q)) : LenW'(gap_q);
    raw     = NumW'(base_q) + NumW'(put_gap);
    raw1    = raw + NumW'(1);
    put_pos = (raw > NumW'(lim)) ? lim : raw[PosW-1:0];
    base_d  = (raw1 > NumW'(cwe_pkg::BaseMax)) ? cwe_pkg::BaseMax : raw1[BaseW-1:0];
    wt_dec  = rem_wt_q - WtW'(1);
    emit    = cmd_i.emit_take || cmd_i.emit_flush;
    out_free = !out_valid_q || out_ready_i;
  end

  assign status_o.wt_zero     = wt_zero;
  assign status_o.flush_need  = flush_need;
  assign status_o.phase_flag  = (phase_q == cwe_pkg::PhaseFlag);
  assign status_o.decode_take = dec_take;
  assign status_o.msg_bit     = msg_bit_q;
  assign status_o.step_take   = step_take;
  assign status_o.out_free    = out_free;

  // control and word state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q  <= cwe_pkg::CodeLengthReset;
      word_wt_q   <= cwe_pkg::WordWeightReset;
      rem_len_q   <= '0;
      rem_wt_q    <= '0;
      gap_q       <= '0;
      base_q      <= '0;
      phase_q     <= cwe_pkg::PhaseFlag;
      bits_left_q <= '0;
      partial_q   <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cwe_pkg::cfg_idx_e'(cfg_index_i))
          cwe_pkg::CfgCodeLength: code_len_q <= cfg_data_i;
          cwe_pkg::CfgWordWeight: word_wt_q  <= cfg_data_i[WtW-1:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.load_item) begin
        if (start_word_i) begin
          rem_len_q   <= eff_len;
          rem_wt_q    <= eff_wt;
          gap_q       <= '0;
          base_q      <= '0;
          phase_q     <= cwe_pkg::PhaseFlag;
          bits_left_q <= '0;
          partial_q   <= '0;
          step_q      <= '0;
        end
      end else if (cmd_i.decode) begin
        if (phase_q == cwe_pkg::PhaseValue) begin
          partial_q   <= partial_shift;
          bits_left_q <= bits_dec;
          if (dec_extra) begin
            phase_q <= cwe_pkg::PhaseExtra;
          end
        end
      end else if (cmd_i.step) begin
        step_q  <= step_d;
        phase_q <= cwe_pkg::PhaseFlag;
        if (msg_bit_q) begin
          rem_len_q <= (LenW'(step_d) > rem_len_q) ? '0 : rem_len_q - LenW'(step_d);
          gap_q     <= gap_q + step_d;
        end else if (!step_take) begin
          partial_q <= '0;
          if (u <= BitsW'(1)) begin
            phase_q <= cwe_pkg::PhaseExtra;
          end else begin
            bits_left_q <= u - BitsW'(1);
            phase_q     <= cwe_pkg::PhaseValue;
          end
        end
      end else if (emit) begin
        rem_wt_q <= wt_dec;
        base_q   <= base_d;
        gap_q    <= '0;
        if (cmd_i.emit_take) begin
          rem_len_q   <= ((LenW'(c_q) + LenW'(1)) > rem_len_q) ? '0
                         : rem_len_q - LenW'(c_q) - LenW'(1);
          phase_q     <= cwe_pkg::PhaseFlag;
          bits_left_q <= '0;
          partial_q   <= '0;
        end else begin
          rem_len_q <= (rem_len_q != '0) ? rem_len_q - LenW'(1) : '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      msg_bit_q <= msg_bit_i;
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(num) * ProdW'(cwe_pkg::WeightFrac[rem_wt_q]);
    end
    if (cmd_i.step) begin
      thr_q <= thr_full[PosW-1:0];
      if (step_take) begin
        c_q <= '0;
      end
    end
    if (cmd_i.decode && dec_take) begin
      c_q <= dec_c;
    end
    if (emit) begin
      pos_q  <= put_pos;
      last_q <= (wt_dec == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign last_one_o  = last_q;

endmodule

`default_nettype wire

### hw/rtl/constant_weight_word_encoder_top.sv
// ----------------------------------------------------------------------------
// constant_weight_word_encoder_top
// run-length constant weight encoder: message bits in, positions of the
// ones of an n-bit word of weight t out
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  cfg       in         cfg_index_i (code_length, word_weight), cfg_data_i
//  s_axis    in         tdata[0] msg_bit, tuser[0] start_word
//  m_axis    out        tdata[11:0] position, tlast last_one
//
//  a value bit passes through accept and decode; a flag bit through accept,
//  decode, the registered step size multiply and step
//  positions are emitted in the take and flush states, then the flush state closes
//  the output register stalls the sequencer while it holds a result and m_axis_tready_i is low
//  reset: code_length 2048, word_weight 32, no word open until start_word
// ----------------------------------------------------------------------------
`default_nettype none

module constant_weight_word_encoder_top (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [cwe_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [cwe_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire                            s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire  [cwe_pkg::InDataW-1:0]    s_axis_tdata_i,   // [0] msg_bit
  input  wire  [0:0]                     s_axis_tuser_i,   // [0] start_word
  output logic                           m_axis_tvalid_o,
  input  wire                            m_axis_tready_i,
  output logic [cwe_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [11:0] position
  output logic                           m_axis_tlast_o
);

  cwe_pkg::cwe_cmd_t    cmd;
  cwe_pkg::cwe_status_t status;
  logic [cwe_pkg::PosW-1:0] position;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  cwe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cwe_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .msg_bit_i    (s_axis_tdata_i[0]),
    .start_word_i (s_axis_tuser_i[0]),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .position_o   (position),
    .last_one_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = cwe_pkg::OutDataW'(position);

endmodule

`default_nettype wire

### hw/rtl/cwe_checker.sv
// ----------------------------------------------------------------------------
// cwe_checker
// port-level checks of the encoder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "constant_weight_word_encoder_top_defines.svh"

module cwe_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid_i,
  input wire                            s_axis_tready_o,
  input wire                            m_axis_tvalid_o,
  input wire                            m_axis_tready_i,
  input wire [cwe_pkg::OutDataW-1:0]    m_axis_tdata_o,
  input wire                            m_axis_tlast_o
);

  // a stalled result holds
  `CWE_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "result changed while stalled")

  // every request goes through the decode state before the next one is taken
  `CWE_ASSERT_NXT(a_one_request, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "request taken on back-to-back cycles")

  // a new result only shows up while the encoder is busy
  `CWE_ASSERT_IMP(a_rise_busy, $rose(m_axis_tvalid_o), !s_axis_tready_o, "result appeared while idle")

  // padding above the position stays zero
  `CWE_ASSERT_IMP(a_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[cwe_pkg::OutDataW-1:cwe_pkg::PosW] == '0, "nonzero padding in result")

endmodule

bind constant_weight_word_encoder_top cwe_checker u_cwe_checker (.*);

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// constant weight word encoder testbench
// feeds message bits and word starts under changing length and weight
// settings, predicts every one position with a bit-true model of the
// run-length encoder and compares each emitted position and last flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  class position_scoreboard;
    int unsigned code_len;
    int unsigned word_wt;
    int unsigned rem_len;
    int unsigned rem_wt;
    int unsigned gap_acc;
    int unsigned base_pos;
    int unsigned bits_left;
    int unsigned partial;
    int unsigned step_d;
    int unsigned n_out;
    cwe_pkg::phase_e rd_phase;
    logic [cwe_pkg::PosW-1:0] pos_q[$];
    logic                     last_q[$];
    int unsigned errors;

    function new();
      code_len  = 2048;
      word_wt   = 32;
      rem_len   = 0;
      rem_wt    = 0;
      gap_acc   = 0;
      base_pos  = 0;
      bits_left = 0;
      partial   = 0;
      step_d    = 0;
      n_out     = 0;
      rd_phase  = cwe_pkg::PhaseFlag;
      errors    = 0;
    endfunction

    function void set_reg(cwe_pkg::cfg_idx_e idx, int unsigned val);
      if (idx == cwe_pkg::CfgCodeLength) begin
        code_len = val % 8192;
      end else begin
        word_wt = val % 64;
      end
    endfunction

    function int unsigned word_len();
      return (code_len > cwe_pkg::LenCap) ? cwe_pkg::LenCap : code_len;
    endfunction

    function int unsigned pending();
      return pos_q.size();
    endfunction

    function bit word_open();
      return rem_wt > 0;
    endfunction

    function int unsigned ceil_log2(int unsigned d);
      int unsigned u;
      u = 0;
      while (u < 16 && (1 << u) < d) u++;
      return u;
    endfunction

    // skip size for m bits left and w ones left
    function int unsigned skip_size(int unsigned m, int unsigned w);
      int unsigned d;
      if (w == 0 || w > 63 || m <= w) return 1;
      d = ((2 * m - w + 1) * cwe_pkg::WeightFrac[w] + 131071) >> 17;
      if (d < 1) d = 1;
      if (d > m - w) d = m - w;
      return d;
    endfunction

    function void place_one(int unsigned gap);
      int unsigned lim;
      int unsigned raw;
      int unsigned pos;
      lim = (word_len() != 0) ? word_len() - 1 : 0;
      raw = base_pos + gap;
      pos = (raw > lim) ? lim : raw;
      if (n_out >= 63) return;
      if (rem_wt > 0) rem_wt--;
      base_pos = (raw + 1 > 8191) ? 8191 : raw + 1;
      pos_q.push_back(pos[cwe_pkg::PosW-1:0]);
      last_q.push_back(rem_wt == 0);
      n_out++;
    endfunction

    function void flush_ones();
      while (rem_wt > 0 && rem_len <= rem_wt && n_out < 63) begin
        if (rem_len > 0) rem_len--;
        place_one(gap_acc);
        gap_acc = 0;
      end
    endfunction

    function void take_offset(int unsigned c);
      if (step_d >= 1 && c >= step_d) c = step_d - 1;
      place_one(gap_acc + c);
      rem_len   = (c + 1 > rem_len) ? 0 : rem_len - c - 1;
      gap_acc   = 0;
      rd_phase  = cwe_pkg::PhaseFlag;
      bits_left = 0;
      partial   = 0;
      flush_ones();
    endfunction

    // returns 0 when the request is ignored (no word open)
    function bit note_input(logic msg, logic start);
      int unsigned d;
      int unsigned u;
      int unsigned thr;
      int unsigned n;
      int unsigned t;
      n_out = 0;
      if (start) begin
        n = word_len();
        t = (word_wt > 63) ? 63 : word_wt;
        if (t > n) t = n;
        rem_len   = n;
        rem_wt    = t;
        gap_acc   = 0;
        base_pos  = 0;
        rd_phase  = cwe_pkg::PhaseFlag;
        bits_left = 0;
        partial   = 0;
        step_d    = 0;
        if (rem_wt > 0 && rem_len <= rem_wt) begin
          flush_ones();
          return 1'b1;
        end
      end
      if (rem_wt == 0) return start;
      case (rd_phase)
        cwe_pkg::PhaseValue: begin
          partial = ((partial << 1) | msg) & 12'hfff;
          if (bits_left > 0) bits_left--;
          if (bits_left == 0) begin
            d = step_d;
            if (d < 2) begin
              take_offset(0);
            end else begin
              thr = (1 << ceil_log2(d)) - d;
              if (partial >= thr) rd_phase = cwe_pkg::PhaseExtra;
              else take_offset(partial);
            end
          end
        end
        cwe_pkg::PhaseExtra: begin
          d = step_d;
          if (d < 2) begin
            take_offset(0);
          end else begin
            thr = (1 << ceil_log2(d)) - d;
            take_offset(2 * partial + msg - thr);
          end
        end
        default: begin
          d = skip_size(rem_len, rem_wt);
          step_d   = d;
          rd_phase = cwe_pkg::PhaseFlag;
          if (msg) begin
            rem_len = (d > rem_len) ? 0 : rem_len - d;
            gap_acc = (gap_acc + d) & 12'hfff;
            flush_ones();
          end else if (d < 2) begin
            take_offset(0);
          end else begin
            u = ceil_log2(d);
            partial = 0;
            if (u <= 1) begin
              rd_phase = cwe_pkg::PhaseExtra;
            end else begin
              bits_left = u - 1;
              rd_phase  = cwe_pkg::PhaseValue;
            end
          end
        end
      endcase
      return 1'b1;
    endfunction

    function void check_result(logic [cwe_pkg::PosW-1:0] pos, logic last_one);
      logic [cwe_pkg::PosW-1:0] exp_pos;
      logic                     exp_last;
      if (pos_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected position %0d, last %0b", $time, pos, last_one);
        return;
      end
      exp_pos  = pos_q.pop_front();
      exp_last = last_q.pop_front();
      if (pos !== exp_pos) begin
        errors++;
        $display("%0t: position mismatch: expected %0d, actual %0d", $time, exp_pos, pos);
      end
      if (last_one !== exp_last) begin
        errors++;
        $display("%0t: last flag mismatch: expected %0b, actual %0b", $time, exp_last,
                 last_one);
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  cwe_pkg::cfg_idx_e            cfg_index_i;
  logic [cwe_pkg::CfgDataW-1:0] cfg_data_i;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  logic [cwe_pkg::InDataW-1:0]  s_axis_tdata_i;   // [0] msg_bit
  logic [0:0]                   s_axis_tuser_i;   // [0] start_word
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  logic [cwe_pkg::OutDataW-1:0] m_axis_tdata_o;   // [11:0] position
  logic                         m_axis_tlast_o;

  position_scoreboard sb;
  int unsigned snd_idle;
  int unsigned rcv_idle;
  int unsigned fed_items;
  logic        hold_req;

  constant_weight_word_encoder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      sb.check_result(m_axis_tdata_o[cwe_pkg::PosW-1:0], m_axis_tlast_o);
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic send_bit(input logic msg, input logic start);
    while ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= cwe_pkg::InDataW'(msg);
    s_axis_tuser_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (sb.note_input(msg, start)) fed_items++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cwe_pkg::cfg_idx_e idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= cwe_pkg::CfgDataW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop sending, wait for every expected position, then let a bit in flight settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic random_config();
    int unsigned len;
    int unsigned wt;
    int unsigned sel;
    sel = $urandom_range(9);
    wt  = $urandom_range(1, 8);
    if (sel == 0) begin
      len = $urandom_range(65, 8191);
      wt  = $urandom_range(1, 2);
    end else if (sel <= 3) begin
      // tight words: skips of one or two, or the whole word at once
      len = wt + $urandom_range(0, 3);
    end else if (sel == 4) begin
      wt  = $urandom_range(40, 63);
      len = wt + $urandom_range(0, 8);
    end else if (sel == 5) begin
      len = $urandom_range(0, 8);
      wt  = $urandom_range(0, 63);
    end else begin
      len = $urandom_range(2, 96);
    end
    write_reg(cwe_pkg::CfgCodeLength, len);
    write_reg(cwe_pkg::CfgWordWeight, wt);
  endtask

  initial begin
    int unsigned mode;
    int unsigned target;
    int unsigned words;
    int unsigned w;
    int unsigned n;
    int unsigned cut;
    bit          broken;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = cwe_pkg::CfgCodeLength;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    snd_idle        = 0;
    rcv_idle        = 0;
    fed_items       = 0;
    hold_req        = 1'b0;
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one skip, then a short value read placing one one
    send_bit(1'b1, 1'b1);
    repeat (6) send_bit(1'b0, 1'b0);
    drain();
    // longest word, single one, skips only: the one lands on the last bit
    write_reg(cwe_pkg::CfgCodeLength, 8191);
    write_reg(cwe_pkg::CfgWordWeight, 1);
    send_bit(1'b1, 1'b1);
    repeat (11) send_bit(1'b1, 1'b0);
    drain();
    // weight above length: whole word at once, then a bit with no word open
    write_reg(cwe_pkg::CfgCodeLength, 3);
    write_reg(cwe_pkg::CfgWordWeight, 63);
    send_bit(1'b0, 1'b1);
    send_bit(1'b1, 1'b0);
    drain();
    write_reg(cwe_pkg::CfgWordWeight, 0);
    send_bit(1'b1, 1'b1);
    drain();
    write_reg(cwe_pkg::CfgCodeLength, 0);
    write_reg(cwe_pkg::CfgWordWeight, 5);
    send_bit(1'b0, 1'b1);
    drain();
    // length shrinks under an open word: the position clamps to n-1
    write_reg(cwe_pkg::CfgCodeLength, 64);
    write_reg(cwe_pkg::CfgWordWeight, 1);
    send_bit(1'b1, 1'b1);
    drain();
    write_reg(cwe_pkg::CfgCodeLength, 16);
    repeat (5) send_bit(1'b0, 1'b0);

    for (mode = 0; mode < 3; mode++) begin
      snd_idle = (mode == 0) ? 31 : (mode == 1) ? 82 : 0;
      rcv_idle = (mode == 0) ? 82 : (mode == 1) ? 31 : 0;
      if (mode == 2) hold_req = 1'b1;
      target = fed_items + 90;
      while (fed_items < target) begin
        drain();
        random_config();
        words = $urandom_range(1, 4);
        for (w = 0; w < words; w++) begin
          // now and then carry an open word on under the new settings
          if (!(w == 0 && sb.word_open() && $urandom_range(3) == 0)) begin
            send_bit(1'($urandom_range(1)), 1'b1);
          end
          broken = ($urandom_range(7) == 0);
          cut    = $urandom_range(1, 20);
          n      = 0;
          while (sb.word_open() && n < 150 && !(broken && n >= cut)) begin
            send_bit(1'($urandom_range(1)), 1'b0);
            n++;
          end
          if ($urandom_range(4) == 0) send_bit(1'($urandom_range(1)), 1'b0);
        end
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### constant_weight_word_encoder_top.f
+incdir+hw/rtl
hw/rtl/cwe_pkg.sv
hw/rtl/cwe_ctrl.sv
hw/rtl/cwe_dp.sv
hw/rtl/constant_weight_word_encoder_top.sv
hw/rtl/cwe_checker.sv
verif/tb.sv
